[sv/sbot_pkg.sv]
package sbot_pkg;
  localparam int COORD_BITS_DEF = 16;
  localparam int LOOP_LIMIT = 32;
endpackage

[sv/sbot_if.sv]
interface sbot_in_if #(parameter int W = 16) (input logic clk);
  logic valid;
  logic ready;
  logic signed [W-1:0] start_x;
  logic signed [W-1:0] start_y;
  logic signed [W-1:0] end_x;
  logic signed [W-1:0] end_y;
  logic signed [W-1:0] box_left;
  logic signed [W-1:0] box_bottom;
  logic signed [W-1:0] box_right;
  logic signed [W-1:0] box_top;
  modport source (output valid, start_x, start_y, end_x, end_y, box_left, box_bottom,
                  box_right, box_top, input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, box_left, box_bottom,
                box_right, box_top, output ready);
endinterface

interface sbot_out_if (input logic clk);
  logic valid;
  logic ready;
  logic touches_box;
  modport source (output valid, touches_box, input ready);
  modport sink (input valid, touches_box, output ready);
endinterface

[sv/sbot_div.sv]
module sbot_div #(
  parameter int NW = 34,
  parameter int DW = 17
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo,
  output logic          rem_nz
);
  localparam int CW = $clog2(NW + 1);
  logic [CW-1:0] cnt;
  logic [DW:0] rem;
  logic [DW-1:0] dv;
  logic busy;
  logic [DW:0] trial;
  logic [DW:0] sub;

  // One restoring division step per cycle.
  assign trial = {rem[DW-1:0], quo[NW-1]};
  assign sub = trial - {1'b0, dv};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= CW'(NW);
      quo <= num;
      dv <= den;
      rem <= '0;
    end else if (busy) begin
      if (!sub[DW]) begin
        rem <= sub;
        quo <= {quo[NW-2:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[NW-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign rem_nz = (rem != '0);
endmodule

[sv/segment_box_overlap_test.sv]
// Segment against box overlap test.
// The input channel carries a segment (two endpoints) and an inclusive box;
// the output channel returns one touches_box flag per accepted item.
// The block takes one item at a time: ready is high only when no item is in
// work and no result is waiting.
// Each item runs a clip sequencer; every clip step uses one shared restoring
// divider, and a clip step passes through the test, multiply, divider start
// and fix-up states.
// The result is offered from the first test step when the segment is
// trivially outside and from the second when both endpoints are already
// inside; otherwise each clip step adds one divider run, and the test steps
// are bounded by LOOP_LIMIT.
// The next item can be taken in the cycle after the result transfer.
// The result stays on the output until it is transferred; while the receiver
// stalls, no new item is taken.
// Synchronous reset clears the sequencer and output valid; nothing else
// needs clearing.
module segment_box_overlap_test
  import sbot_pkg::*;
#(
  parameter int COORD_BITS = sbot_pkg::COORD_BITS_DEF
) (
  input logic clk,
  input logic rst,
  sbot_in_if.sink   in_ch,
  sbot_out_if.source out_ch
);
  localparam int W = COORD_BITS;
  localparam int DW = W + 1;
  localparam int NW = 2 * W + 2;
  localparam int SW = $clog2(LOOP_LIMIT + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TEST = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_FIX  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;
  localparam logic [2:0] S_MUL  = 3'd5;

  logic [2:0] state;
  logic signed [W-1:0] x1, y1, x2, y2, xmin, ymin, xmax, ymax;
  logic inside_run;
  logic [SW-1:0] steps;
  logic res;
  // Clip operands: a moves, b reaches edge e.
  logic signed [W-1:0] ca, ce;
  logic on_y;
  logic signed [DW-1:0] da, db, dd;
  logic neg;
  logic [NW-1:0] prod;
  logic div_start, div_done, rnz;
  logic [NW-1:0] quo;
  logic [DW-1:0] ud;
  logic signed [NW:0] base;

  function automatic logic [DW-1:0] magf(input logic signed [DW-1:0] v);
    magf = v[DW-1] ? DW'(-v) : v;
  endfunction

  sbot_div #(.NW(NW), .DW(DW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(prod), .den(ud),
    .done(div_done), .quo(quo), .rem_nz(rnz)
  );

  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.touches_box = res;
  assign div_start = (state == S_MUL);

  // The whole sum a + fraction is truncated toward zero: take the floor first,
  // then step up by one when a fraction remains and the floor is negative.
  always_comb begin
    base = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    base = base + (NW+1)'(signed'(ca));
    if (neg && rnz) base = base - (NW+1)'(1);
    if (rnz && base < 0) base = base + (NW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: if (in_ch.valid) begin
          x1 <= in_ch.start_x; y1 <= in_ch.start_y;
          x2 <= in_ch.end_x;   y2 <= in_ch.end_y;
          xmin <= in_ch.box_left; ymin <= in_ch.box_bottom;
          xmax <= in_ch.box_right; ymax <= in_ch.box_top;
          inside_run <= 1'b0;
          steps <= '0;
          state <= S_TEST;
        end
        S_TEST: begin
          steps <= steps + 1'b1;
          if (steps == SW'(LOOP_LIMIT)) begin
            res <= 1'b0; state <= S_OUT;
          end else if (y1 > ymax || y1 < ymin || x1 > xmax || x1 < xmin) begin
            inside_run <= 1'b0;
            if ((y1 > ymax && y2 > ymax) || (y1 <= ymax && y1 < ymin && y2 < ymin) ||
                (y1 <= ymax && y1 >= ymin && x1 > xmax && x2 > xmax) ||
                (y1 <= ymax && y1 >= ymin && x1 <= xmax && x1 < xmin && x2 < xmin)) begin
              res <= 1'b0; state <= S_OUT;
            end else begin
              on_y <= (y1 > ymax || y1 < ymin);
              if (y1 > ymax || y1 < ymin) begin
                ca <= x1;
                ce <= (y1 > ymax) ? ymax : ymin;
                da <= DW'(x2) - DW'(x1);
                db <= DW'((y1 > ymax) ? ymax : ymin) - DW'(y1);
                dd <= DW'(y2) - DW'(y1);
              end else begin
                ca <= y1;
                ce <= (x1 > xmax) ? xmax : xmin;
                da <= DW'(y2) - DW'(y1);
                db <= DW'((x1 > xmax) ? xmax : xmin) - DW'(x1);
                dd <= DW'(x2) - DW'(x1);
              end
              state <= S_DIV;
            end
          end else if (inside_run) begin
            res <= 1'b1; state <= S_OUT;
          end else begin
            inside_run <= 1'b1;
            x1 <= x2; y1 <= y2; x2 <= x1; y2 <= y1;
          end
        end
        S_DIV: begin
          // Multiply magnitudes; a register stands before the divider.
          prod <= NW'(magf(da)) * NW'(magf(db));
          ud <= magf(dd);
          neg <= (da[DW-1] ^ db[DW-1]) ^ dd[DW-1];
          state <= S_MUL;
        end
        S_MUL: state <= S_FIX;
        S_FIX: if (div_done) begin
          if (on_y) begin
            x1 <= (ud == '0 || prod == '0) ? ca : W'(base);
            y1 <= ce;
          end else begin
            y1 <= (ud == '0 || prod == '0) ? ca : W'(base);
            x1 <= ce;
          end
          state <= S_TEST;
        end
        S_OUT: if (out_ch.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_ready_busy: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !in_ch.ready) else $error("ready while result pending");
  a_steps: assert property (@(posedge clk) disable iff (rst)
    (state == S_TEST) |-> (steps <= SW'(LOOP_LIMIT))) else $error("step overrun");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(res)))
    else $error("result dropped");
`endif
endmodule

[dv/segment_box_overlap_test_sb.sv]
`timescale 1ns / 100ps

// Scoreboard for the overlap flag: predicts each accepted item and checks
// every result transfer against the oldest prediction.
class overlap_scoreboard;
  bit touch_q[$];
  int mismatches;
  int checked;
  int inside_seen;

  function new();
    mismatches = 0;
    checked = 0;
    inside_seen = 0;
  endfunction

  // Moves a point onto an edge along the segment; the exact value of the
  // whole sum is truncated toward zero.
  static function longint clip_coord(longint a, longint a2, longint b, longint b2,
                                     longint e);
    longint num;
    longint den;
    den = b2 - b;
    if (den == 0) return a;
    num = (a2 - a) * (e - b);
    if (num == 0) return a;
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    return (a * den + num) / den;
  endfunction

  static function bit segment_touches(longint x1, longint y1, longint x2, longint y2,
                                      longint xmin, longint ymin, longint xmax,
                                      longint ymax);
    int run;
    longint t;
    run = 0;
    for (int s = 0; s < sbot_pkg::LOOP_LIMIT; s++) begin
      if (y1 > ymax) begin
        if (y2 > ymax) return 1'b0;
        x1 = clip_coord(x1, x2, y1, y2, ymax);
        y1 = ymax;
        run = 0;
      end else if (y1 < ymin) begin
        if (y2 < ymin) return 1'b0;
        x1 = clip_coord(x1, x2, y1, y2, ymin);
        y1 = ymin;
        run = 0;
      end else if (x1 > xmax) begin
        if (x2 > xmax) return 1'b0;
        y1 = clip_coord(y1, y2, x1, x2, xmax);
        x1 = xmax;
        run = 0;
      end else if (x1 < xmin) begin
        if (x2 < xmin) return 1'b0;
        y1 = clip_coord(y1, y2, x1, x2, xmin);
        x1 = xmin;
        run = 0;
      end else begin
        run++;
        if (run >= 2) return 1'b1;
        t = x1; x1 = x2; x2 = t;
        t = y1; y1 = y2; y2 = t;
      end
    end
    return 1'b0;
  endfunction

  function void note_segment(logic signed [15:0] c[8]);
    bit r;
    r = segment_touches(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
    touch_q.push_back(r);
  endfunction

  function void check_flag(logic flag);
    bit want;
    if (touch_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("Unexpected result transfer: touches_box=%b", flag);
      return;
    end
    want = touch_q.pop_front();
    checked++;
    if (want) inside_seen++;
    if (flag !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Mismatch on result %0d: expected %b, actual %b", checked, want, flag);
    end
  endfunction
endclass

[dv/tb_segment_box_overlap_test.sv]
`timescale 1ns / 100ps

module tb_segment_box_overlap_test;
  localparam int W = sbot_pkg::COORD_BITS_DEF;
  localparam int RANDOM_ITEMS = 1000;

  logic clk;
  logic rst;
  int directed_count;

  sbot_in_if #(.W(W)) in_ch (.clk(clk));
  sbot_out_if out_ch (.clk(clk));

  segment_box_overlap_test #(.COORD_BITS(W)) DUT (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  overlap_scoreboard board = new();

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  // Result receiver with random stalls; each transfer is checked at the edge.
  initial begin
    int rx_idle;
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      rx_idle = $urandom_range(0, 3);
      if (rx_idle > 0) begin
        out_ch.ready <= 1'b0;
        repeat (rx_idle) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      board.check_flag(out_ch.touches_box);
      @(negedge clk);
    end
  end

  // Drives one segment and box, holding it until the transfer. Valid stays
  // high after the transfer when the next item follows with no idle cycles.
  task automatic send_segment(logic signed [W-1:0] c[8]);
    int tx_idle;
    tx_idle = $urandom_range(0, 3);
    if (tx_idle > 0) begin
      in_ch.valid <= 1'b0;
      repeat (tx_idle) @(negedge clk);
    end
    in_ch.start_x <= c[0];
    in_ch.start_y <= c[1];
    in_ch.end_x <= c[2];
    in_ch.end_y <= c[3];
    in_ch.box_left <= c[4];
    in_ch.box_bottom <= c[5];
    in_ch.box_right <= c[6];
    in_ch.box_top <= c[7];
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    board.note_segment(c);
    @(negedge clk);
  endtask

  task automatic send_coords(int a, int b, int cc, int d, int l, int bo, int r, int t);
    logic signed [W-1:0] c[8];
    c[0] = W'(a); c[1] = W'(b); c[2] = W'(cc); c[3] = W'(d);
    c[4] = W'(l); c[5] = W'(bo); c[6] = W'(r); c[7] = W'(t);
    directed_count++;
    send_segment(c);
  endtask

  function automatic logic signed [W-1:0] pick_coord(int lo, int hi);
    if ($urandom_range(0, 9) == 0) return W'($urandom);
    return W'(lo + $signed($urandom_range(0, hi - lo)));
  endfunction

  // Stimulus.
  initial begin
    logic signed [W-1:0] c[8];
    int l, r, b, t;
    directed_count = 0;
    in_ch.valid = 1'b0;
    {in_ch.start_x, in_ch.start_y, in_ch.end_x, in_ch.end_y} = '0;
    {in_ch.box_left, in_ch.box_bottom, in_ch.box_right, in_ch.box_top} = '0;
    rst = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed cases: full-range extremes, crossings, corners and edges.
    send_coords(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767);
    send_coords(-32768, 32767, 32767, -32768, -10, -10, 10, 10);
    send_coords(-32768, -32768, 32767, 32767, 0, 0, 0, 0);
    send_coords(-32768, 0, 32767, 1, -5, -5, 5, 5);
    send_coords(0, -32768, 1, 32767, -5, -5, 5, 5);
    send_coords(20, 20, 30, 30, -10, -10, 10, 10);
    send_coords(-20, -20, -30, -30, -10, -10, 10, 10);
    send_coords(-20, 5, 20, 5, -10, -10, 10, 10);
    send_coords(5, 50, 5, -50, -10, -10, 10, 10);
    send_coords(0, 0, 0, 0, -10, -10, 10, 10);
    send_coords(11, 11, 11, 11, -10, -10, 10, 10);
    send_coords(10, 10, 10, 10, -10, -10, 10, 10);
    send_coords(0, 0, 5, 5, 10, -10, -10, 10);
    send_coords(0, 0, 5, 5, -10, 10, 10, -10);
    send_coords(-20, 0, 0, 20, -10, -10, 10, 10);
    send_coords(-21, 0, 0, 21, -10, -10, 10, 10);
    send_coords(9, 30, 30, 9, -10, -10, 10, 10);
    send_coords(-32768, 32767, -32768, -32768, -32768, -32768, -32768, 32767);
    send_coords(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    send_coords(-3, 7, 13, -9, 0, 0, 4, 4);
    send_coords(-1, -1, 1, 1, 0, 0, 0, 0);

    // Random part: mostly boxes and segments near each other, some full range.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        foreach (c[k]) c[k] = W'($urandom);
      end else begin
        l = $signed($urandom_range(0, 2000)) - 1000;
        b = $signed($urandom_range(0, 2000)) - 1000;
        r = l + $urandom_range(0, 300) - ($urandom_range(0, 19) == 0 ? 350 : 0);
        t = b + $urandom_range(0, 300) - ($urandom_range(0, 19) == 0 ? 350 : 0);
        c[0] = pick_coord(l - 400, l + 700);
        c[1] = pick_coord(b - 400, b + 700);
        c[2] = pick_coord(l - 400, l + 700);
        c[3] = pick_coord(b - 400, b + 700);
        c[4] = W'(l); c[5] = W'(b); c[6] = W'(r); c[7] = W'(t);
      end
      send_segment(c);
    end
    in_ch.valid <= 1'b0;

    // Drain, then allow for the block's latency.
    while (board.touch_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Checked %0d results (%0d directed items), %0d of them touching the box.",
             board.checked, directed_count, board.inside_seen);
    if (board.mismatches == 0 && board.touch_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Mismatches: %0d", board.mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
